// ----- sv/mlr_pkg.sv -----
// shared types, constants and pixel helpers of the midpoint line rasterizer
package mlr_pkg;

   localparam int COORD_W = 6;
   localparam int POS_W = 8;
   localparam int DEC_W = 14;
   localparam int CSR_IDX_W = 1;
   localparam int DEFAULT_GRID_SIZE = 64;
   localparam logic [COORD_W-1:0] GRID_RESET = COORD_W'(15);

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd1;

   typedef struct packed {
      logic [COORD_W-1:0] start_col;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] end_col;
      logic [COORD_W-1:0] end_row;
      logic               thick;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] main_row;
      logic [COORD_W-1:0] main_col;
      logic               main_valid;
      logic [COORD_W-1:0] side_a_row;
      logic [COORD_W-1:0] side_a_col;
      logic               side_a_valid;
      logic [COORD_W-1:0] side_b_row;
      logic [COORD_W-1:0] side_b_col;
      logic               side_b_valid;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               valid;
   } pixel_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_col;
      logic out_free;
   } ctl_sts_type;

   function automatic logic signed [POS_W-1:0] to_pos(input logic [COORD_W-1:0] v);
      return $signed({{(POS_W-COORD_W){1'b0}}, v});
   endfunction

   function automatic logic signed [DEC_W-1:0] to_dec(input logic signed [POS_W-1:0] v);
      return $signed({{(DEC_W-POS_W){v[POS_W-1]}}, v});
   endfunction

   // pixel inside the grid keeps its coordinates, anything else reads as zero
   function automatic pixel_type put_pixel(input logic signed [POS_W-1:0] r,
                                           input logic signed [POS_W-1:0] c,
                                           input logic wr,
                                           input logic [COORD_W-1:0] gr,
                                           input logic [COORD_W-1:0] gc);
      pixel_type p;
      logic ok;
      ok = wr && (r >= 0) && (r <= to_pos(gr)) && (c >= 0) && (c <= to_pos(gc));
      p.row = ok ? r[COORD_W-1:0] : '0;
      p.col = ok ? c[COORD_W-1:0] : '0;
      p.valid = ok;
      return p;
   endfunction

endpackage

// ----- sv/mlr_ctrl.sv -----
// sequencer of the midpoint line rasterizer: accept, setup, column walk
module mlr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mlr_pkg::ctl_sts_type sts,
   output mlr_pkg::ctl_cmd_type cmd
);
   import mlr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SETUP = 2'd1;
   localparam logic [1:0] S_RUN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.last_col) state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_setup: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SETUP) else $error("load not followed by setup");
   a_setup_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SETUP |=> state_ff == S_RUN) else $error("setup not followed by run");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free) else $error("emit into a full output register");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.last_col) |=> state_ff == S_IDLE) else $error("walk ran past last");

endmodule

// ----- sv/mlr_datapath.sv -----
// segment registers, decision update, pixel build and output register
module mlr_datapath #(
   parameter int GRID_SIZE = mlr_pkg::DEFAULT_GRID_SIZE
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mlr_pkg::req_type                req_payload,
   output mlr_pkg::rsp_type                rsp_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            csr_we,
   input  logic [mlr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mlr_pkg::COORD_W-1:0]     csr_wdata,
   input  mlr_pkg::ctl_cmd_type            cmd,
   output mlr_pkg::ctl_sts_type            sts
);
   import mlr_pkg::*;

   localparam int CNT_W = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;

   logic [COORD_W-1:0]      grid_rows_ff, grid_cols_ff;
   logic signed [POS_W-1:0] col_ff, row_ff;
   logic [COORD_W-1:0]      stop_ff, end_row_ff;
   logic signed [DEC_W-1:0] dec_ff, east_ff, diag_ff;
   logic                    up_ff, thick_ff;
   logic [CNT_W-1:0]        cnt_ff;
   rsp_type                 out_ff;
   logic                    out_valid_ff;

   logic                    up_in;
   logic signed [POS_W-1:0] dx, dy;
   logic                    first, last_col, go_east;
   pixel_type               pm, pa, pb;
   rsp_type                 rsp_in;

   // setup arithmetic
   always_comb begin
      up_in = row_ff < to_pos(end_row_ff);
      dx = to_pos(stop_ff) - col_ff;
      dy = up_in ? (to_pos(end_row_ff) - row_ff) : (row_ff - to_pos(end_row_ff));
   end

   // one column of output
   always_comb begin
      first = (cnt_ff == '0);
      last_col = (col_ff >= to_pos(stop_ff)) || (cnt_ff == CNT_W'(GRID_SIZE - 1));
      go_east = up_ff ? (dec_ff <= 0) : (dec_ff < 0);
      pm = put_pixel(row_ff, col_ff, 1'b1, grid_rows_ff, grid_cols_ff);
      if (up_ff) begin
         pa = put_pixel(row_ff, col_ff + 8'sd1, thick_ff, grid_rows_ff, grid_cols_ff);
         pb = put_pixel(row_ff, col_ff - 8'sd1, thick_ff && !first,
                        grid_rows_ff, grid_cols_ff);
      end else if (first) begin
         pa = put_pixel(row_ff - 8'sd1, col_ff, thick_ff, grid_rows_ff, grid_cols_ff);
         pb = put_pixel('0, '0, 1'b0, grid_rows_ff, grid_cols_ff);
      end else begin
         pa = put_pixel(row_ff + 8'sd1, col_ff, thick_ff, grid_rows_ff, grid_cols_ff);
         pb = put_pixel(row_ff - 8'sd1, col_ff, thick_ff, grid_rows_ff, grid_cols_ff);
      end
      rsp_in.main_row = pm.row;
      rsp_in.main_col = pm.col;
      rsp_in.main_valid = pm.valid;
      rsp_in.side_a_row = pa.row;
      rsp_in.side_a_col = pa.col;
      rsp_in.side_a_valid = pa.valid;
      rsp_in.side_b_row = pb.row;
      rsp_in.side_b_col = pb.col;
      rsp_in.side_b_valid = pb.valid;
      rsp_in.last = last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_RESET;
         grid_cols_ff <= GRID_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
               CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.emit) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= to_pos(req_payload.start_col);
         row_ff <= to_pos(req_payload.start_row);
         stop_ff <= req_payload.end_col;
         end_row_ff <= req_payload.end_row;
         thick_ff <= req_payload.thick;
      end
      if (cmd.setup) begin
         up_ff <= up_in;
         dec_ff <= (to_dec(dy) <<< 1) - to_dec(dx);
         east_ff <= to_dec(dy) <<< 1;
         diag_ff <= (to_dec(dy) - to_dec(dx)) <<< 1;
         cnt_ff <= '0;
      end
      if (cmd.emit) begin
         out_ff <= rsp_in;
         if (!last_col) begin
            if (go_east) begin
               dec_ff <= dec_ff + east_ff;
            end else begin
               dec_ff <= dec_ff + diag_ff;
               row_ff <= up_ff ? row_ff + 8'sd1 : row_ff - 8'sd1;
            end
            col_ff <= col_ff + 8'sd1;
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   assign sts.last_col = last_col;
   assign sts.out_free = !out_valid_ff || rsp_ready;
   assign rsp_payload = out_ff;
   assign rsp_valid = out_valid_ff;

endmodule

// ----- sv/midpoint_line_rasterizer_top.sv -----
// top level of the midpoint line rasterizer: sequencer plus datapath
// a segment is taken only in idle and loaded, setup follows, then the column walk
// registers n column beats, n at most GRID_SIZE, before the next segment is taken
// the walk makes one decision update per cycle while the output register is free
// a column beat waits in the output register while the walk stalls on rsp_ready
// reset (synchronous, active high): sequencer idle, no beat pending, grid limits 15
module midpoint_line_rasterizer_top #(
   parameter int GRID_SIZE = mlr_pkg::DEFAULT_GRID_SIZE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mlr_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mlr_pkg::rsp_type              rsp_payload,
   input  logic                          csr_we,
   input  logic [mlr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mlr_pkg::COORD_W-1:0]   csr_wdata
);
   import mlr_pkg::*;

   // command and status between sequencer and datapath
   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequencer: idle takes a segment, setup follows, then one column per free slot
   mlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: grid limits, decision variable, neighbour pixels, output register
   mlr_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ----- sim/midpoint_line_rasterizer_checker.sv -----
// column beat checker of the midpoint line rasterizer: predicts every beat and compares
module midpoint_line_rasterizer_checker #(
   parameter int GRID_SIZE = mlr_pkg::DEFAULT_GRID_SIZE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  mlr_pkg::req_type              req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  mlr_pkg::rsp_type              rsp_payload,
   input  logic                          csr_we,
   input  logic [mlr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mlr_pkg::COORD_W-1:0]   csr_wdata,
   output int                            mismatch_count,
   output int                            beats_due
);

   import mlr_pkg::*;

   logic [COORD_W-1:0] row_limit;
   logic [COORD_W-1:0] col_limit;
   rsp_type            column_beats[$];
   int                 errors = 0;

   // off-grid or unwritten pixels read back as all zero
   function automatic pixel_type grid_pixel(input int r, input int c, input bit drawn);
      pixel_type p;
      p = '0;
      if (drawn && r >= 0 && r <= int'(row_limit) && c >= 0 && c <= int'(col_limit)) begin
         p.row   = r[COORD_W-1:0];
         p.col   = c[COORD_W-1:0];
         p.valid = 1'b1;
      end
      return p;
   endfunction

   // walk the segment column by column, queueing one beat per column
   task automatic trace_segment(input req_type seg);
      int        col;
      int        row;
      int        stop;
      int        dx;
      int        dy;
      int        d;
      int        east;
      int        diag;
      int        n;
      bit        up;
      bit        first;
      bit        fin;
      pixel_type line_px;
      pixel_type side_a;
      pixel_type side_b;
      up   = seg.start_row < seg.end_row;
      col  = seg.start_col;
      row  = seg.start_row;
      stop = seg.end_col;
      dx   = stop - col;
      dy   = up ? int'(seg.end_row) - row : row - int'(seg.end_row);
      d    = 2 * dy - dx;
      east = 2 * dy;
      diag = 2 * (dy - dx);
      n    = 0;
      forever begin
         first   = (n == 0);
         fin     = (col >= stop) || (n + 1 >= GRID_SIZE);
         line_px = grid_pixel(row, col, 1'b1);
         if (up) begin
            side_a = grid_pixel(row, col + 1, seg.thick);
            side_b = grid_pixel(row, col - 1, seg.thick && !first);
         end else if (first) begin
            side_a = grid_pixel(row - 1, col, seg.thick);
            side_b = grid_pixel(0, 0, 1'b0);
         end else begin
            side_a = grid_pixel(row + 1, col, seg.thick);
            side_b = grid_pixel(row - 1, col, seg.thick);
         end
         // beat layout is three pixels then last
         column_beats.push_back({line_px, side_a, side_b, fin});
         n++;
         if (fin)
            break;
         if (up ? (d <= 0) : (d < 0)) begin
            d += east;
         end else begin
            d   += diag;
            row += up ? 1 : -1;
         end
         col++;
      end
   endtask

   task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (column_beats.size() == 0) begin
         $display("%0t: unexpected beat, expected none, got %h", $time, got);
         errors++;
      end else begin
         want = column_beats.pop_front();
         check_field("main_row", want.main_row, got.main_row);
         check_field("main_col", want.main_col, got.main_col);
         check_field("main_valid", COORD_W'(want.main_valid), COORD_W'(got.main_valid));
         check_field("side_a_row", want.side_a_row, got.side_a_row);
         check_field("side_a_col", want.side_a_col, got.side_a_col);
         check_field("side_a_valid", COORD_W'(want.side_a_valid),
                     COORD_W'(got.side_a_valid));
         check_field("side_b_row", want.side_b_row, got.side_b_row);
         check_field("side_b_col", want.side_b_col, got.side_b_col);
         check_field("side_b_valid", COORD_W'(want.side_b_valid),
                     COORD_W'(got.side_b_valid));
         check_field("last", COORD_W'(want.last), COORD_W'(got.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_limit = GRID_RESET;
         col_limit = GRID_RESET;
         column_beats.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_GRID_ROWS)
               row_limit = csr_wdata;
            else if (csr_index == CSR_GRID_COLS)
               col_limit = csr_wdata;
         end
         if (rsp_valid && rsp_ready)
            check_beat(rsp_payload);
         if (req_valid && req_ready)
            trace_segment(req_payload);
      end
      mismatch_count <= errors;
      beats_due      <= column_beats.size();
   end

endmodule

// ----- sim/midpoint_line_rasterizer_top_tb.sv -----
// testbench top of the midpoint line rasterizer: stimulus, handshakes and verdict
module midpoint_line_rasterizer_top_tb;

   import mlr_pkg::*;

   localparam int GRID_SIZE = DEFAULT_GRID_SIZE;
   // slowest run: 503 segments of at most 64 beats, with sink stalls, source gaps
   // and drains; the cycle limit is taken well above what that run needs
   localparam int CYCLE_LIMIT = 500000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_payload;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;

   int mismatches;
   int beats_due;
   int cycle_count = 0;
   // idle chance in percent for each side
   int src_idle_pct = 22;
   int sink_idle_pct = 22;

   midpoint_line_rasterizer_top #(
      .GRID_SIZE(GRID_SIZE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // watches both channels and the register port, owns the expected beats
   midpoint_line_rasterizer_checker #(
      .GRID_SIZE(GRID_SIZE)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatch_count(mismatches),
      .beats_due     (beats_due)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sink side: ready drops at random, never in phase 2 of the random part
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("midpoint_line_rasterizer_top_tb NOT OK");
         $finish;
      end
   end

   function automatic req_type make_segment(input int sc, input int sr, input int ec,
                                            input int er, input bit thick);
      req_type s;
      s.start_col = sc[COORD_W-1:0];
      s.start_row = sr[COORD_W-1:0];
      s.end_col   = ec[COORD_W-1:0];
      s.end_row   = er[COORD_W-1:0];
      s.thick     = thick;
      return s;
   endfunction

   // mostly short segments so the run stays quick, a few full-width ones,
   // some that end left of their start, the rest fully random
   function automatic req_type random_segment();
      int kind;
      int sc;
      int ec;
      kind = $urandom_range(99);
      sc   = $urandom_range(63);
      if (kind < 60) begin
         ec = sc + $urandom_range(12);
         if (ec > 63)
            ec = 63;
      end else if (kind < 75) begin
         ec = $urandom_range(sc);
      end else if (kind < 85) begin
         sc = $urandom_range(3);
         ec = 63 - $urandom_range(3);
      end else begin
         ec = $urandom_range(63);
      end
      return make_segment(sc, $urandom_range(63), ec, $urandom_range(63),
                          $urandom_range(1) == 1);
   endfunction

   // one segment beat; valid stays up across back-to-back beats
   task automatic send_segment(input req_type seg);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= seg;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // hold off the source until every column beat has come back, then let the
   // sequencer settle back to idle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_due != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // both limits in one go; only called while the block is idle
   task automatic set_grid(input int rows, input int cols);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= rows[COORD_W-1:0];
      @(posedge clock);
      csr_index <= CSR_GRID_COLS;
      csr_wdata <= cols[COORD_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_GRID_ROWS;
      csr_wdata   <= '0;
      reset       <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset grid limits of 15, rows and columns 0 to 15
      send_segment(make_segment(5, 5, 5, 5, 0));     // single pixel
      send_segment(make_segment(5, 5, 5, 5, 1));     // single pixel, thick
      send_segment(make_segment(9, 4, 2, 12, 1));    // end left of start
      send_segment(make_segment(0, 5, 10, 5, 1));    // flat line takes the falling branch
      send_segment(make_segment(0, 0, 12, 5, 1));    // rising, shallow, from column 0
      send_segment(make_segment(1, 0, 4, 14, 1));    // rising, steep
      send_segment(make_segment(2, 14, 14, 3, 1));   // falling
      send_segment(make_segment(3, 0, 9, 0, 1));     // row 0, neighbour above the grid
      send_segment(make_segment(10, 10, 20, 30, 1)); // walks off the grid
      send_segment(make_segment(0, 0, 63, 63, 1));   // longest segment, capped walk
      send_segment(make_segment(63, 63, 63, 63, 1)); // corner outside the grid
      send_segment(make_segment(0, 63, 63, 0, 0));   // full falling diagonal
      drain();

      // widest grid
      set_grid(63, 63);
      send_segment(make_segment(0, 0, 63, 63, 1));
      send_segment(make_segment(0, 63, 63, 0, 1));
      send_segment(make_segment(60, 2, 63, 5, 1));   // neighbour at column 64
      send_segment(make_segment(0, 0, 63, 0, 1));
      send_segment(make_segment(40, 63, 50, 63, 1)); // neighbour at row 64
      send_segment(make_segment(63, 0, 0, 63, 1));
      send_segment(make_segment(20, 10, 30, 11, 0));
      drain();

      // single-pixel grid
      set_grid(0, 0);
      send_segment(make_segment(0, 0, 3, 2, 1));
      send_segment(make_segment(0, 0, 0, 0, 1));
      send_segment(make_segment(0, 1, 4, 0, 1));
      send_segment(make_segment(63, 63, 0, 0, 1));
      drain();

      // random part, one grid setting per phase, registers only touched when drained
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_grid(63, 63);
            1: set_grid(0, 0);
            2: set_grid(15, 40);
            3: set_grid(63, 0);
            4: set_grid(0, 63);
            default: set_grid($urandom_range(63), $urandom_range(63));
         endcase
         // phase 2 runs with no idling on either side
         src_idle_pct  = (p == 2) ? 0 : 22;
         sink_idle_pct = (p == 2) ? 0 : 22;
         repeat (80) begin
            send_segment(random_segment());
            // occasional full pause mid-phase
            if ($urandom_range(39) == 0)
               drain();
         end
         drain();
      end

      // every beat back and the block quiet for a while
      if (mismatches == 0)
         $display("midpoint_line_rasterizer_top_tb OK");
      else
         $display("midpoint_line_rasterizer_top_tb NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
sv/mlr_pkg.sv
sv/mlr_ctrl.sv
sv/mlr_datapath.sv
sv/midpoint_line_rasterizer_top.sv
sim/midpoint_line_rasterizer_checker.sv
sim/midpoint_line_rasterizer_top_tb.sv
